// ===== rtl/core/swpd_pkg.sv =====
// Package for the sync word packet deframer.
// Holds the frame constants, word structs, event codes and sync stage type.
// No dependencies.
`timescale 1ns / 1ps

package swpd_pkg;

  localparam int BODY_LEN  = 127;
  localparam int IDX_W     = $clog2(BODY_LEN);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  localparam logic [7:0] SYNC_A   = 8'h5A;
  localparam logic [7:0] SYNC_B   = 8'hA5;
  localparam logic [7:0] SYNC_C   = 8'hC3;
  localparam logic [7:0] END_MARK = 8'hF0;

  localparam logic [7:0]       BODY_LEN_B = 8'(BODY_LEN);
  localparam logic [IDX_W-1:0] LAST_POS   = IDX_W'(BODY_LEN - 1);
  localparam logic [IDX_W-1:0] MARK_POS   = IDX_W'(BODY_LEN - 2);

  typedef enum logic [2:0] {
    EV_ZERO   = 3'd0,
    EV_MISS   = 3'd1,
    EV_SYNC   = 3'd2,
    EV_BODY   = 3'd3,
    EV_ACCEPT = 3'd4,
    EV_REJECT = 3'd5,
    EV_READ   = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    HUNT_A  = 2'd0,
    HUNT_B  = 2'd1,
    HUNT_C  = 2'd2,
    IN_BODY = 2'd3
  } sync_stage_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       supply_ok;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    event_t     event_code;
    logic [7:0] read_data;
    logic       packet_ready;
  } out_word_t;

  // Per-word information carried alongside the store read.
  typedef struct packed {
    event_t ev;
    logic   ready;
    logic   rd_zero;
  } meta_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ===== rtl/core/swpd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/swpd_framer.sv =====
// Frame tracker: sync hunt, body write into the write bank and bank swap.
// Depends on swpd_pkg.
`timescale 1ns / 1ps

module swpd_framer import swpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_word_t word,
  output wr_req_t  wr,
  output rd_req_t  rd,
  output meta_t    meta
);

  sync_stage_t      stage_r, stage_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic             loaded_r, loaded_nxt;
  logic             mark_r, mark_nxt;
  logic             wb;

  assign wb = ~bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= HUNT_A;
      cnt_r    <= '0;
      bank_r   <= 1'b0;
      loaded_r <= 1'b0;
      mark_r   <= 1'b0;
    end else begin
      stage_r  <= stage_nxt;
      cnt_r    <= cnt_nxt;
      bank_r   <= bank_nxt;
      loaded_r <= loaded_nxt;
      mark_r   <= mark_nxt;
    end
  end

  always_comb begin
    stage_nxt    = stage_r;
    cnt_nxt      = cnt_r;
    bank_nxt     = bank_r;
    loaded_nxt   = loaded_r;
    mark_nxt     = mark_r;
    wr.en        = 1'b0;
    wr.addr      = {wb, cnt_r};
    wr.data      = word.rx_byte;
    rd.en        = 1'b0;
    rd.addr      = {bank_r, word.read_index[IDX_W-1:0]};
    meta.ev      = EV_ZERO;
    meta.ready   = 1'b0;
    // Until the first packet is accepted the store reads as all zero.
    meta.rd_zero = !(word.read_index < BODY_LEN_B) || !loaded_r;

    if (word.action) begin
      meta.ev = EV_READ;
      rd.en   = take;
    end else if (word.rx_byte == 8'h00) begin
      meta.ev = EV_ZERO;
    end else begin
      unique case (stage_r)
        HUNT_A: begin
          meta.ev   = (word.rx_byte == SYNC_A) ? EV_SYNC : EV_MISS;
          stage_nxt = (word.rx_byte == SYNC_A) ? HUNT_B : HUNT_A;
        end
        HUNT_B: begin
          meta.ev   = (word.rx_byte == SYNC_B) ? EV_SYNC : EV_MISS;
          stage_nxt = (word.rx_byte == SYNC_B) ? HUNT_C : HUNT_A;
        end
        HUNT_C: begin
          meta.ev   = (word.rx_byte == SYNC_C) ? EV_SYNC : EV_MISS;
          stage_nxt = (word.rx_byte == SYNC_C) ? IN_BODY : HUNT_A;
        end
        IN_BODY: begin
          wr.en = take;
          if (cnt_r == LAST_POS) begin
            // The end mark position is always written earlier in the body,
            // so its test result is already held in mark_r.
            if (mark_r) begin
              meta.ev    = EV_ACCEPT;
              meta.ready = word.supply_ok;
              bank_nxt   = wb;
              loaded_nxt = 1'b1;
            end else begin
              meta.ev = EV_REJECT;
            end
            cnt_nxt   = '0;
            stage_nxt = HUNT_A;
          end else begin
            meta.ev = EV_BODY;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == MARK_POS) begin
              mark_nxt = (word.rx_byte == END_MARK);
            end
          end
        end
        default: begin
          stage_nxt = HUNT_A;
        end
      endcase
    end

    if (!take) begin
      stage_nxt  = stage_r;
      cnt_nxt    = cnt_r;
      bank_nxt   = bank_r;
      loaded_nxt = loaded_r;
      mark_nxt   = mark_r;
    end
  end

endmodule

// ===== rtl/core/sync_word_packet_deframer.sv =====
// Top level of the sync word packet deframer: framer, packet store and output stage.
// Depends on swpd_pkg, swpd_framer and swpd_ram.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | in_word_t
//   out_    | output    | out_valid/out_stall | out_word_t
//
// One word is taken per cycle while in_stall is low; its result is registered first by the
// read port of the packet store, beside its meta, and then by the output register.
// Reset is synchronous and needs no clearing pass: a flag keeps the store
// reading as zero until the first packet is accepted.
// A stalled output holds its word; one more word waits beside the store read,
// and in_stall rises only when both places are full.
`timescale 1ns / 1ps

module sync_word_packet_deframer import swpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      take;
  logic      s1_go;
  logic      s1_valid_r, s1_valid_nxt;
  meta_t     s1_meta_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  wr_req_t   wr;
  rd_req_t   rd;
  meta_t     meta;
  logic [7:0] rdata;

  assign s1_go    = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign take     = in_valid && !in_stall;

  swpd_framer u_framer (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .word  (in_word),
    .wr    (wr),
    .rd    (rd),
    .meta  (meta)
  );

  // Both banks side by side; the bank select is the top address bit.
  swpd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  always_comb begin
    s1_valid_nxt = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    if (s1_valid_r && s1_go) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_meta_r <= meta;
    end
    if (s1_valid_r && s1_go) begin
      out_word_r.event_code   <= s1_meta_r.ev;
      out_word_r.packet_ready <= s1_meta_r.ready;
      out_word_r.read_data    <= (s1_meta_r.ev == EV_READ && !s1_meta_r.rd_zero) ?
                                 rdata : 8'h00;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sync_word_packet_deframer: directed table, then random frames.
// Each accepted word is run through a predictor of the framer and packet store, and the
// result words are compared in order. Depends on swpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import swpd_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  sync_word_packet_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  typedef struct {
    in_word_t  w;
    int        reps;
    bit        typed;
    out_word_t res;
  } stim_row_t;

  // Predictor state: hunting stage, body position and the two packet banks.
  sync_stage_t hunt_stage;
  int          body_pos;
  logic [7:0]  pkt_bank [2][BODY_LEN];
  logic        live_bank;

  out_word_t   events_due[$];
  stim_row_t   dir_rows[$];
  int          mismatches = 0;
  int          counted_items = 0;
  int          in_calm = 0;
  int          out_calm = 0;
  int          stall_left = 0;

  function automatic out_word_t deframe_event(in_word_t w);
    out_word_t  r;
    logic       wb;
    logic [7:0] want;
    sync_stage_t nxt;
    r  = '{EV_READ, 8'h00, 1'b0};
    wb = ~live_bank;
    if (w.action) begin
      if (w.read_index < BODY_LEN) r.read_data = pkt_bank[live_bank][w.read_index];
    end else if (w.rx_byte == 8'h00) begin
      r.event_code = EV_ZERO;
    end else if (hunt_stage != IN_BODY) begin
      case (hunt_stage)
        HUNT_A:  begin want = SYNC_A; nxt = HUNT_B; end
        HUNT_B:  begin want = SYNC_B; nxt = HUNT_C; end
        default: begin want = SYNC_C; nxt = IN_BODY; end
      endcase
      // A wrong byte is not tried again as a first sync byte.
      if (w.rx_byte == want) begin
        hunt_stage   = nxt;
        r.event_code = EV_SYNC;
      end else begin
        hunt_stage   = HUNT_A;
        r.event_code = EV_MISS;
      end
    end else begin
      pkt_bank[wb][body_pos] = w.rx_byte;
      body_pos++;
      r.event_code = EV_BODY;
      if (body_pos >= BODY_LEN) begin
        if (pkt_bank[wb][BODY_LEN-2] == END_MARK) begin
          live_bank      = wb;
          r.event_code   = EV_ACCEPT;
          r.packet_ready = w.supply_ok;
        end else begin
          r.event_code = EV_REJECT;
        end
        body_pos   = 0;
        hunt_stage = HUNT_A;
      end
    end
    return r;
  endfunction

  function automatic void add_row(bit act, logic [7:0] b, bit sup, logic [7:0] idx, int reps,
                                  bit typed, event_t ev, logic [7:0] data, bit rdy);
    stim_row_t row;
    row.w     = '{act, b, sup, idx};
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{ev, data, rdy};
    dir_rows.push_back(row);
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t res;
    int        gap;
    int        pick;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = deframe_event(w);
    events_due.push_back(typed ? typed_res : res);
    counted_items++;
    gap = 0;
    if (in_calm > 0) begin
      in_calm--;
    end else begin
      if ($urandom_range(0, 199) == 0) in_calm = $urandom_range(50, 300);
      pick = $urandom_range(0, 99);
      if (pick >= 97) gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic byte_word(input logic [7:0] b);
    in_word_t w;
    w = '{1'b0, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
    send_word(w, 1'b0, '0);
  endtask

  task automatic read_word();
    in_word_t w;
    logic [7:0] idx;
    idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, BODY_LEN - 1));
    w = '{1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx};
    send_word(w, 1'b0, '0);
  endtask

  // Sync, then a body with random content; zero words and reads are mixed in at random.
  task automatic send_frame(input bit good);
    logic [7:0] b;
    byte_word(SYNC_A);
    byte_word(SYNC_B);
    byte_word(SYNC_C);
    for (int pos = 0; pos < BODY_LEN; pos++) begin
      if ($urandom_range(0, 19) == 0) byte_word(8'h00);
      if ($urandom_range(0, 19) == 0) read_word();
      b = 8'($urandom_range(1, 255));
      if (pos == BODY_LEN - 2) begin
        if (good) b = END_MARK;
        else if (b == END_MARK) b = 8'h0F;
      end
      byte_word(b);
    end
  endtask

  initial begin
    int pick;
    hunt_stage = HUNT_A;
    body_pos   = 0;
    live_bank  = 1'b0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < BODY_LEN; j++) pkt_bank[i][j] = 8'h00;

    // After reset and plain hunting, including a miss that is not retried.
    add_row(1, 8'h00, 0, 8'd0,   1, 1, EV_READ, 8'h00, 0);
    add_row(1, 8'hFF, 1, 8'd255, 1, 1, EV_READ, 8'h00, 0);
    add_row(0, 8'h00, 1, 8'hFF,  1, 1, EV_ZERO, 8'h00, 0);
    add_row(0, 8'hFF, 0, 8'd0,   1, 1, EV_MISS, 8'h00, 0);
    add_row(0, SYNC_A, 0, 8'd0,  1, 1, EV_SYNC, 8'h00, 0);
    add_row(0, SYNC_B, 0, 8'd0,  1, 1, EV_SYNC, 8'h00, 0);
    add_row(0, SYNC_A, 0, 8'd0,  1, 1, EV_MISS, 8'h00, 0);
    add_row(0, SYNC_A, 0, 8'd0,  1, 1, EV_SYNC, 8'h00, 0);
    add_row(0, SYNC_B, 0, 8'd0,  1, 1, EV_SYNC, 8'h00, 0);
    add_row(0, SYNC_C, 0, 8'd0,  1, 1, EV_SYNC, 8'h00, 0);
    // Body holding sync values, a dropped zero, then accepted with supply good.
    add_row(0, SYNC_A, 0, 8'd0,  1, 1, EV_BODY, 8'h00, 0);
    add_row(0, 8'h00, 1, 8'd3,   1, 1, EV_ZERO, 8'h00, 0);
    add_row(0, 8'h80, 1, 8'd0, 123, 0, EV_ZERO, 8'h00, 0);
    add_row(0, SYNC_B, 0, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, END_MARK, 0, 8'd0, 1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, 8'hFF, 1, 8'd0,   1, 1, EV_ACCEPT, 8'h00, 1);
    add_row(1, 8'h00, 0, 8'd0,   1, 0, EV_ZERO, 8'h00, 0);
    add_row(1, 8'h00, 0, 8'd125, 1, 0, EV_ZERO, 8'h00, 0);
    add_row(1, 8'h00, 0, 8'd126, 1, 0, EV_ZERO, 8'h00, 0);
    add_row(1, 8'hFF, 1, BODY_LEN_B, 1, 1, EV_READ, 8'h00, 0);
    // Rejected body: the accepted packet must survive it.
    add_row(0, SYNC_A, 1, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, SYNC_B, 1, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, SYNC_C, 1, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, 8'h01, 1, 8'd0, 126, 0, EV_ZERO, 8'h00, 0);
    add_row(0, 8'h01, 1, 8'd0,   1, 1, EV_REJECT, 8'h00, 0);
    add_row(1, 8'h00, 0, 8'd1,   1, 0, EV_ZERO, 8'h00, 0);
    // Accepted with supply low: no ready pulse, banks swap back.
    add_row(0, SYNC_A, 0, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, SYNC_B, 0, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, SYNC_C, 0, 8'd0,  1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, 8'hFF, 1, 8'd0, 125, 0, EV_ZERO, 8'h00, 0);
    add_row(0, END_MARK, 1, 8'd0, 1, 0, EV_ZERO, 8'h00, 0);
    add_row(0, 8'h7E, 0, 8'd0,   1, 1, EV_ACCEPT, 8'h00, 0);
    add_row(1, 8'h00, 0, 8'd126, 1, 0, EV_ZERO, 8'h00, 0);
    add_row(1, 8'h00, 0, 8'd124, 1, 0, EV_ZERO, 8'h00, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    // Let the pipeline drain completely before the random part.
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);

    while (counted_items < 1800) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame($urandom_range(0, 9) < 7);
      end else if (pick < 80) begin
        // Broken sync, or a sync followed by only part of a body.
        byte_word(SYNC_A);
        if ($urandom_range(0, 1)) byte_word(SYNC_B);
        if ($urandom_range(0, 3) == 0) begin
          byte_word(SYNC_C);
          repeat ($urandom_range(1, 20)) byte_word(8'($urandom_range(1, 255)));
        end else begin
          byte_word(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 2) == 0) read_word();
          else byte_word(8'($urandom_range(0, 255)));
        end
      end
    end

    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result checking and receiver stalls.
  always @(posedge clk) begin : rx_side
    out_word_t want;
    int        pick;
    if (rst_n && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected word ev=%0d data=%02h ready=%0b",
                   out_word.event_code, out_word.read_data, out_word.packet_ready);
      end else begin
        want = events_due.pop_front();
        if (out_word.event_code !== want.event_code || out_word.read_data !== want.read_data
            || out_word.packet_ready !== want.packet_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp ev=%0d data=%02h ready=%0b got ev=%0d data=%02h ready=%0b",
                     want.event_code, want.read_data, want.packet_ready,
                     out_word.event_code, out_word.read_data, out_word.packet_ready);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_calm > 0) begin
      out_calm--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(50, 300);
      pick = $urandom_range(0, 99);
      if (pick >= 97) stall_left = $urandom_range(20, 60);
      else if (pick >= 75) stall_left = $urandom_range(1, 3);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
